// ===== src/ioa_pkg.sv =====
// Shared constants, types and status codes for the interval overlap admission block.
package ioa_pkg;

  localparam int MAX_POINTS = 256;
  localparam int TIME_W     = 32;
  localparam int DELTA_W    = 10;
  localparam int LIMIT_W    = 4;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int MRG_W      = $clog2(MAX_POINTS + 3);
  localparam int ADDR_W     = IDX_W + 1;
  localparam int SUM_W      = DELTA_W + 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

  localparam logic [STATUS_W-1:0] STATUS_BOOKED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0]  tm;
    logic [DELTA_W-1:0] delta;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                idle;
    logic                done;
    logic [STATUS_W-1:0] status;
  } seq_stat_t;

endpackage

// ===== src/ioa_if.sv =====
// Channel interfaces: request, response and configuration write.
interface ioa_req_if import ioa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  modport source (output valid, start_time, end_time, input ready);
  modport sink (input valid, start_time, end_time, output ready);
endinterface

interface ioa_resp_if import ioa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  modport source (output valid, status, input ready);
  modport sink (input valid, status, output ready);
endinterface

interface ioa_cfg_if import ioa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/interval_overlap_admission.sv =====
// Top level of the interval overlap admission block.
//
//  channel | dir | payload                  | transaction
//  req     | in  | start_time, end_time     | one reservation request
//  resp    | out | status                   | one outcome per request
//  cfg     | in  | data (max_overlap)       | one limit write
//
// A request walks the breakpoint memory, one entry per cycle through its single
// read port except in a cycle that inserts a new key, over the n breakpoints held
// (up to MAX_POINTS) and the k keys it adds (0 to 2); a booked request then
// rewrites its start and end keys (S_FIX_S, S_FIX_E), and an invalid range skips
// the walk. Reset empties the table by clearing the fill count; no clearing pass.
// req is not ready while a request is in work; a stalled result holds resp
// and the next request may be accepted meanwhile.
module interval_overlap_admission import ioa_pkg::*; (
  input logic       clk,
  input logic       rst,
  ioa_req_if.sink   req,
  ioa_resp_if.source resp,
  ioa_cfg_if.sink   cfg
);

  logic [LIMIT_W-1:0]  max_overlap;
  logic                resp_valid;
  logic [STATUS_W-1:0] resp_status;
  logic                resp_free;
  mem_req_t            mem_req;
  entry_t              rdata;
  seq_stat_t           stat;

  assign req.ready   = stat.idle && !rst;
  assign cfg.ready   = !rst;
  assign resp.valid  = resp_valid;
  assign resp.status = resp_status;
  assign resp_free   = !resp_valid || resp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_overlap <= LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_overlap <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (stat.done) begin
      resp_valid  <= 1'b1;
      resp_status <= stat.status;
    end else if (resp.ready) begin
      resp_valid <= 1'b0;
    end
  end

  ioa_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (req.valid && req.ready),
    .start_time  (req.start_time),
    .end_time    (req.end_time),
    .max_overlap (max_overlap),
    .resp_free   (resp_free),
    .rdata       (rdata),
    .mem_req     (mem_req),
    .stat        (stat)
  );

  ioa_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

// ===== src/ioa_mem.sv =====
// Breakpoint memory: two banks of sorted entries, one write and one read port.
module ioa_mem import ioa_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [0:2*MAX_POINTS-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== src/ioa_seq.sv =====
// Merge sequencer: walks the live bank, inserts the two keys into the other bank,
// accumulates the coverage count and decides the outcome.
module ioa_seq import ioa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TIME_W-1:0]  start_time,
  input  logic [TIME_W-1:0]  end_time,
  input  logic [LIMIT_W-1:0] max_overlap,
  input  logic               resp_free,
  input  entry_t             rdata,
  output mem_req_t           mem_req,
  output seq_stat_t          stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_MERGE = 3'd2;
  localparam logic [2:0] S_FIX_S = 3'd3;
  localparam logic [2:0] S_FIX_E = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  localparam logic [1:0] P_START = 2'd0;
  localparam logic [1:0] P_END   = 2'd1;
  localparam logic [1:0] P_NONE  = 2'd2;

  logic [2:0]          state;
  logic                bank;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    i;
  logic [MRG_W-1:0]    j;
  logic [MRG_W-1:0]    js;
  logic [MRG_W-1:0]    je;
  logic [DELTA_W-1:0]  ds;
  logic [DELTA_W-1:0]  de;
  logic [TIME_W-1:0]   s;
  logic [TIME_W-1:0]   e;
  logic [1:0]          pend;
  logic [SUM_W-1:0]    sum;
  logic                ovf;
  logic [STATUS_W-1:0] status;

  logic               have_old;
  logic               have_key;
  logic [TIME_W-1:0]  key_tm;
  logic [SUM_W-1:0]   key_d;
  logic               take_key;
  logic               hit;
  logic               consume;
  logic               merge_done;
  entry_t             emit;
  logic [SUM_W-1:0]   mod;
  logic [SUM_W-1:0]   sum_next;
  logic               over;
  logic [CNT_W-1:0]   i_inc;
  logic               j_room;
  logic               full;

  always_comb begin
    have_old   = i < n;
    have_key   = pend != P_NONE;
    key_tm     = (pend == P_START) ? s : e;
    key_d      = (pend == P_START) ? SUM_W'(1) : {SUM_W{1'b1}};
    take_key   = have_key && (!have_old || rdata.tm >= key_tm);
    hit        = take_key && have_old && rdata.tm == key_tm;
    consume    = have_old && (!take_key || hit);
    merge_done = !have_old && !have_key;
    if (take_key && !hit) begin
      emit.tm    = key_tm;
      emit.delta = '0;
      mod        = key_d;
    end else begin
      emit = rdata;
      mod  = {{(SUM_W-DELTA_W){rdata.delta[DELTA_W-1]}}, rdata.delta};
      if (hit) begin
        mod = mod + key_d;
      end
    end
    sum_next = sum + mod;
    over     = $signed(sum_next) > $signed({{(SUM_W-LIMIT_W){1'b0}}, max_overlap});
    i_inc    = i + CNT_W'(1);
    j_room   = j < MRG_W'(MAX_POINTS);
    full     = j > MRG_W'(MAX_POINTS);
  end

  always_comb begin
    mem_req       = '0;
    mem_req.raddr = {bank, (state == S_PRIME) ? {IDX_W{1'b0}} : i_inc[IDX_W-1:0]};
    mem_req.re    = (state == S_PRIME) || (state == S_MERGE && consume);
    unique case (state)
      S_MERGE: begin
        mem_req.we    = !merge_done && j_room;
        mem_req.waddr = {~bank, j[IDX_W-1:0]};
        mem_req.wdata = emit;
      end
      S_FIX_S: begin
        mem_req.we          = 1'b1;
        mem_req.waddr       = {~bank, js[IDX_W-1:0]};
        mem_req.wdata.tm    = s;
        mem_req.wdata.delta = ds + DELTA_W'(1);
      end
      S_FIX_E: begin
        mem_req.we          = 1'b1;
        mem_req.waddr       = {~bank, je[IDX_W-1:0]};
        mem_req.wdata.tm    = e;
        mem_req.wdata.delta = de - DELTA_W'(1);
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bank  <= 1'b0;
      n     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            s     <= start_time;
            e     <= end_time;
            state <= S_PRIME;
          end
        end
        S_PRIME: begin
          i    <= '0;
          j    <= '0;
          pend <= P_START;
          sum  <= '0;
          ovf  <= 1'b0;
          if (s >= e) begin
            status <= STATUS_INVALID;
            state  <= S_RESP;
          end else begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (merge_done) begin
            // the merged bank becomes live unless the table would overflow
            priority if (full) begin
              status <= STATUS_FULL;
              state  <= S_RESP;
            end else if (ovf) begin
              status <= STATUS_REFUSED;
              bank   <= ~bank;
              n      <= j[CNT_W-1:0];
              state  <= S_RESP;
            end else begin
              state <= S_FIX_S;
            end
          end else begin
            j   <= j + MRG_W'(1);
            sum <= sum_next;
            if (over) begin
              ovf <= 1'b1;
            end
            if (consume) begin
              i <= i_inc;
            end
            if (take_key) begin
              pend <= pend + 2'd1;
              if (pend == P_START) begin
                js <= j;
                ds <= emit.delta;
              end else begin
                je <= j;
                de <= emit.delta;
              end
            end
          end
        end
        S_FIX_S: begin
          state <= S_FIX_E;
        end
        S_FIX_E: begin
          status <= STATUS_BOOKED;
          bank   <= ~bank;
          n      <= j[CNT_W-1:0];
          state  <= S_RESP;
        end
        S_RESP: begin
          if (resp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle   = state == S_IDLE;
  assign stat.done   = (state == S_RESP) && resp_free;
  assign stat.status = status;

endmodule

// ===== src/ioa_checker.sv =====
// Port-level checks for the interval overlap admission block, bound to the top level.
module ioa_checker import ioa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                resp_valid,
  input logic                resp_ready,
  input logic [STATUS_W-1:0] resp_status
);

  // one request at a time: busy right after a transaction
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp_status))
    else $error("stalled response changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !resp_valid)
    else $error("response valid after reset");

  // a fresh result only comes out of a busy period
  a_resp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(resp_valid) |-> $past(!req_ready))
    else $error("response without a request in work");

endmodule

bind interval_overlap_admission ioa_checker u_ioa_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .resp_valid  (resp.valid),
  .resp_ready  (resp.ready),
  .resp_status (resp.status)
);

// ===== tb/interval_overlap_admission_tb.sv =====
// Self-checking testbench for the interval overlap admission block.
`timescale 1ns / 1ps

module interval_overlap_admission_tb;
  import ioa_pkg::*;

  localparam int HOLD_CYCLES = 700;
  localparam int POOL_N      = 150;
  localparam logic [TIME_W-1:0] POOL_STEP = 32'd28_000_000;

  logic clk = 1'b0;
  logic rst;

  ioa_req_if  req_ch ();
  ioa_resp_if resp_ch ();
  ioa_cfg_if  cfg_ch ();

  interval_overlap_admission i_dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .resp (resp_ch),
    .cfg  (cfg_ch)
  );

  always #4 clk = ~clk;

  // Shadow of the breakpoint table and the limit register
  logic [TIME_W-1:0]         bp_time  [MAX_POINTS];
  logic signed [DELTA_W-1:0] bp_delta [MAX_POINTS];
  int                        bp_count;
  logic [LIMIT_W-1:0]        limit_model;

  logic [STATUS_W-1:0] pending_status [$];
  logic [TIME_W-1:0]   pool [POOL_N];
  int                  err_count  = 0;
  bit                  gaps_on    = 1'b1;
  int                  hold_asked = 0;
  int                  hold_given = 0;

  // First used slot whose time is not below t
  function automatic int slot_of(input logic [TIME_W-1:0] t);
    int i;
    i = 0;
    while (i < bp_count && bp_time[i] < t) i++;
    return i;
  endfunction

  function automatic bit has_point(input logic [TIME_W-1:0] t);
    int i;
    i = slot_of(t);
    return i < bp_count && bp_time[i] == t;
  endfunction

  function automatic int place_point(input logic [TIME_W-1:0] t);
    int i;
    i = slot_of(t);
    if (i < bp_count && bp_time[i] == t) return i;
    for (int k = bp_count; k > i; k--) begin
      bp_time[k]  = bp_time[k-1];
      bp_delta[k] = bp_delta[k-1];
    end
    bp_time[i]  = t;
    bp_delta[i] = '0;
    bp_count++;
    return i;
  endfunction

  function automatic logic [STATUS_W-1:0] admission_status(input logic [TIME_W-1:0] s,
                                                           input logic [TIME_W-1:0] e);
    int need;
    int is;
    int ie;
    int sum;
    if (s >= e) return STATUS_INVALID;
    need = 0;
    if (!has_point(s)) need++;
    if (!has_point(e)) need++;
    if (bp_count + need > MAX_POINTS) return STATUS_FULL;
    is = place_point(s);
    bp_delta[is] += 1;
    ie = place_point(e);
    bp_delta[ie] -= 1;
    sum = 0;
    for (int i = 0; i < bp_count; i++) begin
      sum += bp_delta[i];
      if (sum > int'(limit_model)) begin
        // keys stay, changes are undone
        bp_delta[is] -= 1;
        bp_delta[ie] += 1;
        return STATUS_REFUSED;
      end
    end
    return STATUS_BOOKED;
  endfunction

  // valid is left high after a transaction; the next call or wait_idle decides
  task automatic send_request(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e);
    while (gaps_on && $urandom_range(99) < 14) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.start_time <= s;
    req_ch.end_time   <= e;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_status.push_back(admission_status(s, e));
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    limit_model = v;
  endtask

  // Short run across the sorted pool; a few reversed or empty ranges as noise
  task automatic send_pool_request();
    int i;
    int j;
    i = $urandom_range(POOL_N - 1);
    if ($urandom_range(99) < 6) begin
      j = $urandom_range(i);
    end else begin
      j = i + $urandom_range(1, 6);
      if (j > POOL_N - 1) j = POOL_N - 1;
    end
    send_request(pool[i], pool[j]);
  endtask

  task automatic test_directed();
    send_request(32'd5, 32'd5);
    send_request(32'd9, 32'd3);
    send_request(32'd0, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd0);
    send_request(32'd10, 32'd20);
    send_request(32'd10, 32'd20);
    send_request(32'd0, 32'hFFFF_FFFF);  // whole range, over the limit
    send_request(32'd15, 32'd25);
    send_request(32'd20, 32'd30);        // touches an existing end
    send_request(32'd5, 32'd10);
    send_request(32'd0, 32'd1);
    send_request(32'd0, 32'd1);
    send_request(32'd0, 32'd1);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(32'd25, 32'd26);
    send_request(32'd19, 32'd21);
  endtask

  task automatic test_zero_limit();
    set_limit(4'd0);
    send_request(32'd40, 32'd50);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'd7, 32'd7);
    repeat (6) send_pool_request();
  endtask

  task automatic test_single_overlap();
    set_limit(4'd1);
    repeat (140) send_pool_request();
  endtask

  // response side stalls long enough for the block to fill and stop taking requests
  task automatic test_backpressure();
    hold_asked++;
    repeat (12) send_pool_request();
  endtask

  task automatic test_mid_limit();
    set_limit(LIMIT_W'($urandom_range(3, 14)));
    repeat (140) send_pool_request();
  endtask

  task automatic test_wide_limit();
    set_limit(4'd15);
    gaps_on = 1'b0;
    repeat (140) send_pool_request();
    gaps_on = 1'b1;
  endtask

  // fresh keys until the table runs out, mixed with requests on known keys
  task automatic test_table_full();
    int unsigned r;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    logic [TIME_W-1:0] t;
    repeat (120) begin
      r = $urandom_range(99);
      if (r < 25) begin
        send_pool_request();
      end else begin
        s = (r < 50) ? pool[$urandom_range(POOL_N - 1)] : $urandom;
        e = $urandom;
        if (s > e) begin
          t = s;
          s = e;
          e = t;
        end
        send_request(s, e);
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.start_time = '0;
    req_ch.end_time   = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    bp_count          = 0;
    limit_model       = LIMIT_RESET;
    for (int k = 0; k < POOL_N; k++)
      pool[k] = TIME_W'(k) * POOL_STEP + TIME_W'($urandom_range(POOL_STEP - 1));
    pool[0]          = '0;
    pool[POOL_N - 1] = '1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_zero_limit();
    test_single_overlap();
    test_backpressure();
    test_mid_limit();
    test_wide_limit();
    test_table_full();
    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    resp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_given != hold_asked) begin
        resp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_given++;
      end
      resp_ch.ready <= !(gaps_on && $urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    logic [STATUS_W-1:0] want;
    if (!rst && resp_ch.valid && resp_ch.ready) begin
      if (pending_status.size() == 0) begin
        $error("status: no transaction expected, actual %0d", resp_ch.status);
        err_count++;
      end else begin
        want = pending_status.pop_front();
        if (resp_ch.status !== want) begin
          $error("status: expected %0d, actual %0d", want, resp_ch.status);
          err_count++;
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
src/ioa_pkg.sv
src/ioa_if.sv
src/ioa_mem.sv
src/ioa_seq.sv
src/interval_overlap_admission.sv
src/ioa_checker.sv
tb/interval_overlap_admission_tb.sv
